[rtl/hjg_pkg.sv]
// ----------------------------------------------------------------------------
// hjg_pkg
// Shared widths, defaults, controller states and the command/status structs
// of the Halton jitter generator.
// ----------------------------------------------------------------------------
package hjg_pkg;

  // Fixed field widths
  localparam int IN_W  = 32;
  localparam int CFG_W = 11;
  localparam int OUT_W = 16;

  // Parameter defaults
  localparam int FRACTION_BITS_DEF = 16;
  localparam int MAX_SEQUENCE_DEF  = 1024;

  // Sequence length after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd8;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_IDX   = 6'b000100,
    S_DIGIT = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // latch magnitude, clear modulo remainder
    logic mod_step;    // one bit of the magnitude modulo length
    logic idx_load;    // form index, base 2 inverse, start base 3 digits
    logic digit_step;  // peel one base 3 digit
    logic div_init;    // seed the fraction divider
    logic div_step;    // one quotient bit
    logic out_load;    // register the saturated jitter pair
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic x_zero;      // all base 3 digits consumed
  } status_t;

endpackage : hjg_pkg

[rtl/halton_jitter_generator_top.sv]
// Sequencing: the 32-step modulo unit, the index step, the digit loop (one step per
//   base 3 digit of the index, at most 7 with MAX_SEQUENCE 1024), the one-bit-per-cycle
//   fraction divider and the output load run in turn; a new start is taken only once
//   the block is idle again, which it is in the done_o cycle.
// Reset: rst_ni clears the controller and sets sequence_length to 8; done_o is high
//   for a single cycle, as the receiver cannot stall; the jitter pair stays registered.
// ----------------------------------------------------------------------------
// halton_jitter_generator_top
// Frame number in, Halton base 2 / base 3 subpixel jitter pair out (signed Q0.16).
// ----------------------------------------------------------------------------
module halton_jitter_generator_top #(
  parameter int FRACTION_BITS = hjg_pkg::FRACTION_BITS_DEF,
  parameter int MAX_SEQUENCE  = hjg_pkg::MAX_SEQUENCE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hjg_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [hjg_pkg::IN_W-1:0]  frame_index_i,
  output logic                             done_o,
  output logic signed [hjg_pkg::OUT_W-1:0] jitter_x_o,
  output logic signed [hjg_pkg::OUT_W-1:0] jitter_y_o
);

  localparam int IdxW = $clog2(MAX_SEQUENCE + 1);

  logic [hjg_pkg::CFG_W-1:0] seq_len_q;
  logic [31:0]               len_ext;
  logic [31:0]               len_clamp;
  logic [IdxW-1:0]           seq_len;
  hjg_pkg::cmd_t             cmd;
  hjg_pkg::status_t          status;

  // Sequence length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= hjg_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      seq_len_q <= cfg_wdata_i;
    end
  end

  // Zero reads as one, oversize saturates
  assign len_ext = 32'(seq_len_q);
  always_comb begin
    if (len_ext == 32'd0) begin
      len_clamp = 32'd1;
    end else if (len_ext > 32'(MAX_SEQUENCE)) begin
      len_clamp = 32'(MAX_SEQUENCE);
    end else begin
      len_clamp = len_ext;
    end
  end
  assign seq_len = len_clamp[IdxW-1:0];

  hjg_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  hjg_datapath #(
    .FRACTION_BITS(FRACTION_BITS),
    .MAX_SEQUENCE (MAX_SEQUENCE)
  ) u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .frame_index_i(frame_index_i),
    .seq_len_i    (seq_len),
    .jitter_x_o   (jitter_x_o),
    .jitter_y_o   (jitter_y_o)
  );

endmodule : halton_jitter_generator_top

[rtl/hjg_ctrl.sv]
// ----------------------------------------------------------------------------
// hjg_ctrl
// Sequencing state machine: modulo, index, base 3 digit loop, fraction
// divider and result strobe.
// ----------------------------------------------------------------------------
module hjg_ctrl #(
  parameter int FRACTION_BITS = hjg_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  hjg_pkg::status_t status_i,
  output hjg_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  localparam int MaxSteps = (hjg_pkg::IN_W > FRACTION_BITS) ? hjg_pkg::IN_W : FRACTION_BITS;
  localparam int CntW     = $clog2(MaxSteps);

  hjg_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      hjg_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = hjg_pkg::S_MOD;
        end
      end
      hjg_pkg::S_MOD: begin
        cmd_o.mod_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(hjg_pkg::IN_W - 1)) begin
          state_d = hjg_pkg::S_IDX;
        end
      end
      hjg_pkg::S_IDX: begin
        cmd_o.idx_load = 1'b1;
        state_d        = hjg_pkg::S_DIGIT;
      end
      hjg_pkg::S_DIGIT: begin
        if (status_i.x_zero) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = hjg_pkg::S_DIV;
        end else begin
          cmd_o.digit_step = 1'b1;
        end
      end
      hjg_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(FRACTION_BITS - 1)) begin
          state_d = hjg_pkg::S_FIN;
        end
      end
      hjg_pkg::S_FIN: begin
        cmd_o.out_load = 1'b1;
        state_d        = hjg_pkg::S_IDLE;
      end
      default: begin
        state_d = hjg_pkg::S_IDLE;
      end
    endcase
  end

  // Strobe is registered with the output register load, so done_o and the new pair appear together
  assign done_d = (state_q == hjg_pkg::S_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hjg_pkg::S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != hjg_pkg::S_IDLE);
  assign done_o = done_q;

endmodule : hjg_ctrl

[rtl/hjg_datapath.sv]
// ----------------------------------------------------------------------------
// hjg_datapath
// Bit-serial modulo, base 2 bit reversal, base 3 digit extraction, radix-2
// fraction divider and output saturation.
// ----------------------------------------------------------------------------
module hjg_datapath #(
  parameter int FRACTION_BITS = hjg_pkg::FRACTION_BITS_DEF,
  parameter int MAX_SEQUENCE  = hjg_pkg::MAX_SEQUENCE_DEF
) (
  input  logic                            clk_i,
  input  hjg_pkg::cmd_t                   cmd_i,
  output hjg_pkg::status_t                status_o,
  input  logic signed [hjg_pkg::IN_W-1:0] frame_index_i,
  input  logic [$clog2(MAX_SEQUENCE+1)-1:0] seq_len_i,
  output logic signed [hjg_pkg::OUT_W-1:0] jitter_x_o,
  output logic signed [hjg_pkg::OUT_W-1:0] jitter_y_o
);

  localparam int IdxW = $clog2(MAX_SEQUENCE + 1);
  localparam int DenW = $clog2(3 * MAX_SEQUENCE + 1);
  localparam int F    = FRACTION_BITS;
  localparam int VW   = (F + 1 > hjg_pkg::OUT_W + 1) ? F + 1 : hjg_pkg::OUT_W + 1;
  localparam int PW   = 2 * IdxW;

  // floor(2^IdxW / 3): reciprocal for the divide-by-three step
  localparam logic [IdxW-1:0] Recip3 = IdxW'((1 << IdxW) / 3);

  localparam logic signed [VW-1:0] Half   = VW'(2 ** (F - 1));
  localparam logic signed [VW-1:0] OutMin = VW'(-32768);
  localparam logic signed [VW-1:0] OutMax = VW'(32767);

  logic [hjg_pkg::IN_W-1:0] mag_q, mag_d;
  logic [IdxW-1:0]          rem_q, rem_d;
  logic [IdxW-1:0]          x_q, x_d;
  logic [DenW-1:0]          num_q, num_d;
  logic [DenW-1:0]          den_q, den_d;
  logic [DenW:0]            drem_q, drem_d;
  logic [F-1:0]             quot_q, quot_d;
  logic [F-1:0]             q2_q, q2_d;
  logic signed [hjg_pkg::OUT_W-1:0] jx_q, jx_d, jy_q, jy_d;

  logic [hjg_pkg::IN_W-1:0] raw;
  logic [IdxW:0]            mod_t;
  logic [IdxW-1:0]          idx;
  logic [IdxW-1:0]          rev;
  logic [IdxW+F-1:0]        rev_wide;
  logic [PW-1:0]            prod;
  logic [IdxW-1:0]          q_est;
  logic [IdxW+1:0]          r_est;
  logic [IdxW-1:0]          x_next;
  logic [1:0]               digit;
  logic [DenW:0]            div_t;

  // Subtract one half and clamp to the 16-bit signed range
  function automatic logic signed [hjg_pkg::OUT_W-1:0] to_jitter(input logic [F-1:0] q);
    logic signed [VW-1:0] v;
    v = $signed({{(VW - F){1'b0}}, q}) - Half;
    if (v < OutMin) begin
      v = OutMin;
    end else if (v > OutMax) begin
      v = OutMax;
    end
    return v[hjg_pkg::OUT_W-1:0];
  endfunction

  // Raw frame number; its magnitude is taken on load, the most negative input maps to 2^31
  assign raw = frame_index_i;

  // Restoring modulo step: shift in one magnitude bit
  assign mod_t = {rem_q, mag_q[hjg_pkg::IN_W-1]};

  // Index and its base 2 inverse by bit reversal
  assign idx = rem_q + 1'b1;
  always_comb begin
    for (int i = 0; i < IdxW; i++) begin
      rev[i] = idx[IdxW-1-i];
    end
  end
  assign rev_wide = {rev, {F{1'b0}}};

  // Divide by three: reciprocal estimate, then one correction
  assign prod  = PW'(x_q) * PW'(Recip3);
  assign q_est = prod[PW-1:IdxW];
  assign r_est = (IdxW + 2)'(x_q) - (((IdxW + 2)'(q_est) << 1) + (IdxW + 2)'(q_est));
  always_comb begin
    if (r_est >= (IdxW + 2)'(3)) begin
      x_next = q_est + 1'b1;
      digit  = 2'(r_est - (IdxW + 2)'(3));
    end else begin
      x_next = q_est;
      digit  = r_est[1:0];
    end
  end

  // Fraction divider trial shift
  assign div_t = {drem_q[DenW-1:0], 1'b0};

  // Register next values
  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    x_d    = x_q;
    num_d  = num_q;
    den_d  = den_q;
    drem_d = drem_q;
    quot_d = quot_q;
    q2_d   = q2_q;
    jx_d   = jx_q;
    jy_d   = jy_q;

    if (cmd_i.load) begin
      mag_d = raw[hjg_pkg::IN_W-1] ? (hjg_pkg::IN_W'(0) - raw) : raw;
      rem_d = '0;
    end

    if (cmd_i.mod_step) begin
      mag_d = {mag_q[hjg_pkg::IN_W-2:0], 1'b0};
      if (mod_t >= {1'b0, seq_len_i}) begin
        rem_d = IdxW'(mod_t - {1'b0, seq_len_i});
      end else begin
        rem_d = IdxW'(mod_t);
      end
    end

    if (cmd_i.idx_load) begin
      x_d   = idx;
      num_d = '0;
      den_d = DenW'(1);
      q2_d  = rev_wide[IdxW+F-1:IdxW];
    end

    if (cmd_i.digit_step) begin
      x_d   = x_next;
      num_d = (num_q << 1) + num_q + DenW'(digit);
      den_d = (den_q << 1) + den_q;
    end

    if (cmd_i.div_init) begin
      drem_d = {1'b0, num_q};
      quot_d = '0;
    end

    if (cmd_i.div_step) begin
      if (div_t >= {1'b0, den_q}) begin
        drem_d = div_t - {1'b0, den_q};
        quot_d = {quot_q[F-2:0], 1'b1};
      end else begin
        drem_d = div_t;
        quot_d = {quot_q[F-2:0], 1'b0};
      end
    end

    if (cmd_i.out_load) begin
      jx_d = to_jitter(q2_q);
      jy_d = to_jitter(quot_q);
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    x_q    <= x_d;
    num_q  <= num_d;
    den_q  <= den_d;
    drem_q <= drem_d;
    quot_q <= quot_d;
    q2_q   <= q2_d;
    jx_q   <= jx_d;
    jy_q   <= jy_d;
  end

  assign status_o.x_zero = (x_q == '0);
  assign jitter_x_o      = jx_q;
  assign jitter_y_o      = jy_q;

endmodule : hjg_datapath

[rtl/hjg_checker.sv]
// ----------------------------------------------------------------------------
// hjg_checker
// Port-level checks on the start/busy/done sequencing of the generator.
// ----------------------------------------------------------------------------
module hjg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // A result beat lasts exactly one cycle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // An accepted start makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("start accepted but busy not raised");

  // The result beat comes while the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done_o while busy");

  // Finishing an item always delivers its result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result beat");

endmodule : hjg_checker

bind halton_jitter_generator_top hjg_checker u_hjg_checker (.*);

[test/tb_halton_jitter_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_halton_jitter_generator_top
// Self-checking bench for the Halton jitter generator: frame numbers go in
// through the start/busy handshake and each jitter pair on done_o is compared
// with a fixed-point prediction of the base 2 and base 3 radical inverses.
// ----------------------------------------------------------------------------
module tb_halton_jitter_generator_top;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_FRAMES = 120;
  localparam int DRAIN_CYCLES = 70;

  typedef struct {
    logic signed [hjg_pkg::OUT_W-1:0] x;
    logic signed [hjg_pkg::OUT_W-1:0] y;
  } jitter_pair_t;

  // Expected jitter pairs, one per accepted frame, oldest first
  class jitter_scoreboard;
    logic [hjg_pkg::CFG_W-1:0] seq_len = hjg_pkg::CFG_RESET;
    jitter_pair_t              expected_pairs[$];
    int                        errors;
    int                        checked;

    // floor(radical inverse of idx in base b, scaled by 2^FRACTION_BITS)
    function longint unsigned halton_fixed(int unsigned idx, int unsigned b);
      longint unsigned num = 0;
      longint unsigned den = 1;
      while (idx != 0) begin
        num = num * b + idx % b;
        idx = idx / b;
        den = den * b;
      end
      return (num << hjg_pkg::FRACTION_BITS_DEF) / den;
    endfunction

    // Remove one half and clamp to the 16-bit output range
    function logic signed [hjg_pkg::OUT_W-1:0] centre_jitter(longint unsigned q);
      longint v;
      v = longint'(q) - (longint'(1) << (hjg_pkg::FRACTION_BITS_DEF - 1));
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v[hjg_pkg::OUT_W-1:0];
    endfunction

    function void note_frame(logic [hjg_pkg::IN_W-1:0] raw);
      logic [hjg_pkg::IN_W-1:0] mag;
      int unsigned              len;
      int unsigned              idx;
      jitter_pair_t             pair;
      mag = raw[hjg_pkg::IN_W-1] ? (32'd0 - raw) : raw;
      len = 32'(seq_len);
      if (len == 0) len = 1;
      if (len > hjg_pkg::MAX_SEQUENCE_DEF) len = hjg_pkg::MAX_SEQUENCE_DEF;
      idx = (mag % len) + 1;
      pair.x = centre_jitter(halton_fixed(idx, 2));
      pair.y = centre_jitter(halton_fixed(idx, 3));
      expected_pairs.push_back(pair);
    endfunction

    function void check_pair(logic signed [hjg_pkg::OUT_W-1:0] x,
                             logic signed [hjg_pkg::OUT_W-1:0] y);
      jitter_pair_t exp_pair;
      if (expected_pairs.size() == 0) begin
        $error("unexpected jitter pair x=%0d y=%0d", x, y);
        errors++;
        return;
      end
      exp_pair = expected_pairs.pop_front();
      checked++;
      if (x !== exp_pair.x) begin
        $error("jitter_x: expected %0d, got %0d", exp_pair.x, x);
        errors++;
      end
      if (y !== exp_pair.y) begin
        $error("jitter_y: expected %0d, got %0d", exp_pair.y, y);
        errors++;
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [hjg_pkg::CFG_W-1:0]        cfg_wdata_i;
  logic                             start;
  logic                             busy;
  logic signed [hjg_pkg::IN_W-1:0]  frame_index_i;
  logic                             done_o;
  logic signed [hjg_pkg::OUT_W-1:0] jitter_x_o;
  logic signed [hjg_pkg::OUT_W-1:0] jitter_y_o;

  jitter_scoreboard sb;
  int               cycle_count;
  int               frames_sent;
  int               length_writes;

  halton_jitter_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .frame_index_i (frame_index_i),
    .done_o        (done_o),
    .jitter_x_o    (jitter_x_o),
    .jitter_y_o    (jitter_y_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result beats cannot be held off: check each one as it goes by
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_pair(jitter_x_o, jitter_y_o);
  end

  // One frame beat; an optional hold-off first, sometimes timed from idle
  task automatic send_frame(input logic [hjg_pkg::IN_W-1:0] value, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        while (busy) @(negedge clk_i);
      end
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    frame_index_i <= value;
    do @(posedge clk_i); while (busy);
    sb.note_frame(value);
    frames_sent++;
  endtask

  // Drop start and wait for every outstanding pair
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.expected_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Length register write, only with the block idle
  task automatic write_length(input logic [hjg_pkg::CFG_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.seq_len = value;
    length_writes++;
  endtask

  function automatic int pick_gap(bit idle_on);
    if (idle_on && $urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Frame mix: full range, small +/-, near the extremes, around multiples of the length
  function automatic logic [hjg_pkg::IN_W-1:0] random_frame(
    logic [hjg_pkg::CFG_W-1:0] cfg
  );
    int unsigned len;
    len = 32'(cfg);
    if (len == 0) len = 1;
    if (len > hjg_pkg::MAX_SEQUENCE_DEF) len = hjg_pkg::MAX_SEQUENCE_DEF;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 3000);
      2: return 32'd0 - $urandom_range(0, 3000);
      3: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
                                     : 32'h7FFF_FFFF - $urandom_range(0, 15);
      default: begin
        logic [hjg_pkg::IN_W-1:0] m;
        m = len * $urandom_range(0, 2000) + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? m : 32'd0 - m;
      end
    endcase
  endfunction

  initial begin
    logic [hjg_pkg::CFG_W-1:0] len_val;
    bit                        idle_on;
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    start         = 1'b0;
    frame_index_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset length of 8, extremes and sign edges of the frame number
    send_frame(32'd0, 0);
    send_frame(32'd1, 0);
    send_frame(32'd7, 0);
    send_frame(32'd8, 1);
    send_frame(32'd9, 0);
    send_frame(32'hFFFF_FFFF, 0);
    send_frame(32'hFFFF_FFF8, 2);
    send_frame(32'h7FFF_FFFF, 0);
    send_frame(32'h8000_0000, 0);
    send_frame(32'h8000_0001, 3);

    // Zero length behaves as one
    write_length(11'd0);
    send_frame(32'd12345, 0);
    send_frame(32'hFFFF_FFFB, 0);

    // Oversized length saturates to the maximum sequence
    write_length(11'd2047);
    send_frame(32'd1023, 0);
    send_frame(32'd1024, 0);
    send_frame(32'hFFFF_FBFF, 0);

    // Longest legal sequence: index reaches 1024
    write_length(11'd1024);
    send_frame(32'd1023, 0);
    send_frame(32'h7FFF_FFFF, 0);
    send_frame(32'h8000_0000, 0);
    send_frame(32'hFFFF_FC01, 0);

    write_length(11'd1);
    send_frame(32'h7FFF_FFFF, 0);

    write_length(11'd3);
    send_frame(32'h8000_0000, 0);
    send_frame(32'd2, 0);
    send_frame(32'hFFFF_FFFE, 0);

    // Random phases, each under its own length; the last has no idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       len_val = 11'd1;
        1:       len_val = 11'd1024;
        2:       len_val = 11'd0;
        3:       len_val = 11'd2047;
        4:       len_val = 11'd1025;
        5:       len_val = 11'd2;
        6:       len_val = hjg_pkg::CFG_W'($urandom_range(0, 2047));
        default: len_val = hjg_pkg::CFG_W'($urandom_range(1, 1024));
      endcase
      write_length(len_val);
      idle_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        send_frame(random_frame(len_val), pick_gap(idle_on));
      end
    end

    // Drain, then watch a while longer for stray result beats
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d frame numbers under %0d length settings (reset, zero, oversized,",
             frames_sent, length_writes + 1);
    $display("extremes and random); %0d jitter pairs checked, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
